@@ design/gtzs_pkg.sv @@
// package: register indexes, field widths and register reset values for the gradient trigger
package gtzs_pkg;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int DIST_W    = 8;
    localparam int THR_W     = 16;
    localparam int PRE_W     = 11;
    localparam int POST_W    = 14;
    localparam int CNT_W     = 15;
    localparam int FILL_W    = 8;
    localparam int BACK_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // register reset values
    localparam logic [DIST_W-1:0] DIST_RESET = 8'd100;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'hFF9C;
    localparam logic [PRE_W-1:0]  PRE_RESET  = 11'd640;
    localparam logic [POST_W-1:0] POST_RESET = 14'd3200;

    // saturation limits of the counters
    localparam logic [CNT_W-1:0]  SINCE_MAX = 15'h7FFF;
    localparam logic [FILL_W-1:0] FILL_MAX  = 8'hFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISTANCE  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_PRE       = 2'd2,
        REG_POST      = 2'd3
    } cfg_index_t;

    // history read request from the top level to the memory
    typedef struct packed {
        logic        rd_en;
        logic [15:0] addr_old;
        logic [15:0] addr_del;
    } hist_rd_req_t;

endpackage

@@ design/gtzs_history.sv @@
// sample history memory: one write port, two registered read ports
module gtzs_history #(
    parameter int DEPTH = 2048
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [gtzs_pkg::SAMPLE_W-1:0] wr_data,
    input  gtzs_pkg::hist_rd_req_t      rd_req,
    output logic [gtzs_pkg::SAMPLE_W-1:0] rd_old,
    output logic [gtzs_pkg::SAMPLE_W-1:0] rd_del
);
    import gtzs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_old_reg;
    logic [SAMPLE_W-1:0] rd_del_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_req.rd_en) begin
            rd_old_reg <= mem[rd_req.addr_old[AW-1:0]];
            rd_del_reg <= mem[rd_req.addr_del[AW-1:0]];
        end
    end

    assign rd_old = rd_old_reg;
    assign rd_del = rd_del_reg;

endmodule

@@ design/gradient_trigger_zero_suppression.sv @@
// top level: gradient trigger and windowed zero suppression of an adc sample stream
//
//  channel  dir  handshake           contents
//  s_       in   s_tvalid/s_tready   s_tdata[15:0] adc_sample
//  m_       out  m_tvalid/m_tready   m_tdata[15:0] kept_sample, m_tuser block_first,
//                                    m_tlast block_last
//  cfg_     in   cfg_we              cfg_index, cfg_wdata (no read-back)
//
// one word per clock unless a stall or offset load holds s_tready; a word goes from
// s_ to m_ via the history read (one registered memory port pair) and the trigger
// decision and output register. reset (aresetn low, synchronous) clears pointers,
// counters, arm flag and gate; the history memory is not cleared. after reset and
// after a write to the distance or pre count register, s_tready stays low while the
// offset is loaded and while HISTORY_DEPTH is folded out of distance + pre count.
// a stall on m_ holds the decision stage and, through it, s_tready.
module gradient_trigger_zero_suppression #(
    parameter int HISTORY_DEPTH = 2048,
    parameter int WINDOW_MAX    = 128,
    parameter int PRE_MAX       = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] adc_sample
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [15:0] kept_sample
    output logic        m_tuser,      // [0] block_first
    output logic        m_tlast,      // block_last
    // configuration writes
    input  logic                              cfg_we,
    input  logic [gtzs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gtzs_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
    import gtzs_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    // configuration registers
    logic [DIST_W-1:0] dist_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [PRE_W-1:0]  pre_reg;
    logic [POST_W-1:0] post_reg;

    // pointers and counters
    logic [AW-1:0]     wp_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              armed_clear_reg;
    logic [CNT_W-1:0]  since_reg;
    logic [CNT_W-1:0]  gate_reg;

    // delayed-read offset, folded below HISTORY_DEPTH
    logic              load_reg;
    logic [BACK_W-1:0] back_reg;
    logic              folding;

    // decision stage
    logic                s1_valid_reg;
    logic                s1_fill_ok_reg;
    logic                s1_fwd_reg;
    logic [SAMPLE_W-1:0] s1_now_reg;

    // output register
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;
    logic                m_first_reg;
    logic                m_last_reg;

    logic [DIST_W-1:0]   dist_eff;
    logic [PRE_W-1:0]    pre_eff;
    logic [CNT_W-1:0]    total;
    logic                s_accept;
    logic                s1_go;
    hist_rd_req_t        rd_req;
    logic [SAMPLE_W-1:0] rd_old;
    logic [SAMPLE_W-1:0] rd_del;

    logic [SAMPLE_W-1:0] grad;
    logic                accepted;
    logic                armed_clear_next;
    logic [CNT_W-1:0]    since_next;
    logic [CNT_W-1:0]    gate_eff;
    logic [CNT_W-1:0]    gate_next;
    logic                emit;
    logic [SAMPLE_W-1:0] del_sample;

    // effective distance and pre count
    always_comb begin
        dist_eff = dist_reg;
        if (dist_reg == '0) begin
            dist_eff = DIST_W'(1);
        end else if (32'(dist_reg) > WINDOW_MAX) begin
            dist_eff = DIST_W'(WINDOW_MAX);
        end
        pre_eff = pre_reg;
        if (32'(pre_reg) > PRE_MAX) begin
            pre_eff = PRE_W'(PRE_MAX);
        end
    end

    assign total = CNT_W'(pre_eff) + CNT_W'(post_reg);

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= DIST_RESET;
            thr_reg  <= THR_RESET;
            pre_reg  <= PRE_RESET;
            post_reg <= POST_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_DISTANCE:  dist_reg <= cfg_wdata[DIST_W-1:0];
                REG_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                REG_PRE:       pre_reg  <= cfg_wdata[PRE_W-1:0];
                REG_POST:      post_reg <= cfg_wdata[POST_W-1:0];
                default:       dist_reg <= dist_reg;
            endcase
        end
    end

    // fold distance + pre count into the history depth, one subtraction a cycle
    assign folding = (32'(back_reg) >= HISTORY_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b1;
            back_reg <= '0;
        end else if (cfg_we && (cfg_index_t'(cfg_index) == REG_DISTANCE ||
                                cfg_index_t'(cfg_index) == REG_PRE)) begin
            load_reg <= 1'b1;
        end else if (load_reg) begin
            load_reg <= 1'b0;
            back_reg <= BACK_W'(dist_eff) + BACK_W'(pre_eff);
        end else if (folding) begin
            back_reg <= back_reg - BACK_W'(HISTORY_DEPTH);
        end
    end

    // handshake
    assign s1_go    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !load_reg && !folding && (!s1_valid_reg || s1_go);
    assign s_accept = s_tvalid && s_tready;

    // history read addresses behind the write pointer
    always_comb begin
        rd_req.rd_en = s_accept;
        if (32'(wp_reg) >= 32'(dist_eff)) begin
            rd_req.addr_old = 16'(32'(wp_reg) - 32'(dist_eff));
        end else begin
            rd_req.addr_old = 16'(32'(wp_reg) + HISTORY_DEPTH - 32'(dist_eff));
        end
        if (32'(wp_reg) >= 32'(back_reg)) begin
            rd_req.addr_del = 16'(32'(wp_reg) - 32'(back_reg));
        end else begin
            rd_req.addr_del = 16'(32'(wp_reg) + HISTORY_DEPTH - 32'(back_reg));
        end
    end

    gtzs_history #(
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (wp_reg),
        .wr_data (s_tdata),
        .rd_req  (rd_req),
        .rd_old  (rd_old),
        .rd_del  (rd_del)
    );

    // write pointer and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (s_accept) begin
            wp_reg <= (32'(wp_reg) == HISTORY_DEPTH - 1) ? '0 : wp_reg + AW'(1);
            if (fill_reg != FILL_MAX) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // decision stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // decision stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_now_reg     <= s_tdata;
            s1_fill_ok_reg <= (fill_reg >= dist_eff);
            s1_fwd_reg     <= (back_reg == '0);
        end
    end

    // gradient, arm flag and spacing count
    assign grad = s1_now_reg - rd_old;

    always_comb begin
        accepted         = 1'b0;
        armed_clear_next = armed_clear_reg;
        since_next       = since_reg;
        if (s1_fill_ok_reg) begin
            if ($signed(grad) > $signed(thr_reg)) begin
                armed_clear_next = 1'b0;
            end else if ($signed(grad) < $signed(thr_reg) && !armed_clear_reg) begin
                accepted = (since_reg >= total);
            end
            if (accepted) begin
                armed_clear_next = 1'b1;
                since_next       = CNT_W'(1);
            end else if (since_reg != SINCE_MAX) begin
                since_next = since_reg + CNT_W'(1);
            end
        end
    end

    // gate
    always_comb begin
        gate_eff   = accepted ? total : gate_reg;
        emit       = (gate_eff != '0);
        gate_next  = emit ? gate_eff - CNT_W'(1) : gate_eff;
        del_sample = s1_fwd_reg ? s1_now_reg : rd_del;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_clear_reg <= 1'b0;
            since_reg       <= '0;
            gate_reg        <= '0;
        end else if (s1_go) begin
            armed_clear_reg <= armed_clear_next;
            since_reg       <= since_next;
            gate_reg        <= gate_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && emit) begin
            m_data_reg  <= del_sample;
            m_first_reg <= accepted;
            m_last_reg  <= (gate_eff == CNT_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_first_reg;
    assign m_tlast  = m_last_reg;

    // no word is taken while the read offset is being folded
    a_no_accept_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_reg || folding) |-> !s_accept)
        else $error("word accepted while read offset not settled");

    // an accepted word reaches the decision stage
    a_accept_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted word lost before decision stage");

    // a window word that is not the last leaves the gate open
    a_gate_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && emit && gate_eff != CNT_W'(1)) |=> gate_reg != '0)
        else $error("gate closed before last word of window");

    // the fill count never falls
    a_fill_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> fill_reg >= $past(fill_reg))
        else $error("fill count decreased");

endmodule

@@ bench/tb_gradient_trigger_zero_suppression.sv @@
// testbench: gradient trigger zero suppression against a cycle-free window predictor
module tb_gradient_trigger_zero_suppression;
    timeunit 1ns;
    timeprecision 1ps;

    import gtzs_pkg::*;

    localparam int HISTORY_DEPTH = 2048;
    localparam int WINDOW_MAX    = 128;
    localparam int PRE_MAX       = 1024;
    localparam int GEN           = 0;   // state that runs ahead while words are queued
    localparam int CHK           = 1;   // state that follows accepted words

    // trigger state and register copy
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [THR_W-1:0]  thr;
        logic [PRE_W-1:0]  pre;
        logic [POST_W-1:0] post;
        logic [10:0]       wp;
        logic [FILL_W-1:0] fill;
        logic              disarmed;
        logic [CNT_W-1:0]  since;
        logic [CNT_W-1:0]  gate;
        logic [11:0]       stored;
    } trig_state_t;

    // one kept word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
        logic                last;
    } kept_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    logic [SAMPLE_W-1:0] history [2][HISTORY_DEPTH];
    trig_state_t         trig [2];
    kept_t               kept_due [$];
    logic [15:0]         tx_words [$];

    int   fails        = 0;
    int   kept_planned = 0;
    int   tx_gap       = 0;
    int   rx_hold      = 0;
    logic tx_calm      = 1'b0;
    logic rx_calm      = 1'b0;
    logic wave_uniform = 1'b0;
    int   wave_base    = 0;
    int   wave_level   = 0;

    gradient_trigger_zero_suppression #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .WINDOW_MAX    (WINDOW_MAX),
        .PRE_MAX       (PRE_MAX)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [15:0] adc_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [15:0] kept_sample
        .m_tuser   (m_tuser),      // [0] block_first
        .m_tlast   (m_tlast),      // block_last
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial forever #5 aclk = ~aclk;

    // effective distance, saturated to 1..WINDOW_MAX
    function automatic int dist_eff(input logic [DIST_W-1:0] v);
        if (v < 1) return 1;
        if (v > WINDOW_MAX) return WINDOW_MAX;
        return int'(v);
    endfunction

    function automatic int pre_eff(input logic [PRE_W-1:0] v);
        if (v > PRE_MAX) return PRE_MAX;
        return int'(v);
    endfunction

    // one sample through the trigger; returns 1 when a kept word comes out
    function automatic logic trigger_step(input int side, input logic [15:0] x,
                                          output kept_t kept, output logic unwritten);
        trig_state_t s;
        int          d;
        int          p;
        int          total;
        int          back;
        logic [15:0] grad;
        logic        fire;
        logic        emit;
        s         = trig[side];
        d         = dist_eff(s.distance);
        p         = pre_eff(s.pre);
        total     = p + int'(s.post);
        fire      = 1'b0;
        emit      = 1'b0;
        unwritten = 1'b0;
        kept      = '0;
        history[side][s.wp] = x;
        // gradient over the distance, once enough samples are held
        if (int'(s.fill) >= d) begin
            grad = x - history[side][(int'(s.wp) + HISTORY_DEPTH - d) % HISTORY_DEPTH];
            if ($signed(grad) > $signed(s.thr)) begin
                s.disarmed = 1'b0;
            end else if ($signed(grad) < $signed(s.thr) && !s.disarmed
                         && int'(s.since) >= total) begin
                fire = 1'b1;
            end
            if (fire) begin
                s.disarmed = 1'b1;
                s.since    = CNT_W'(1);
                s.gate     = CNT_W'(total);
            end else if (s.since != SINCE_MAX) begin
                s.since = s.since + 1'b1;
            end
        end
        // open window: word delayed by distance plus pre count
        if (s.gate != 0) begin
            back        = d + p;
            unwritten   = back > int'(s.stored);
            kept.sample = history[side][(int'(s.wp) + HISTORY_DEPTH - back) % HISTORY_DEPTH];
            kept.first  = fire;
            kept.last   = (s.gate == CNT_W'(1));
            s.gate      = s.gate - 1'b1;
            emit        = 1'b1;
        end
        if (s.fill != FILL_MAX) s.fill = s.fill + 1'b1;
        s.wp = s.wp + 1'b1;
        if (int'(s.stored) < HISTORY_DEPTH) s.stored = s.stored + 1'b1;
        trig[side] = s;
        return emit;
    endfunction

    // swap a sample that would open a window reaching behind the first stored sample
    function automatic logic [15:0] keep_in_history(input logic [15:0] x);
        trig_state_t saved;
        kept_t       k;
        logic        bad;
        logic        emit;
        saved = trig[GEN];
        emit  = trigger_step(GEN, x, k, bad);
        trig[GEN] = saved;
        if (!bad) return x;
        // gradient lands exactly on the threshold, so the arm state holds
        return history[GEN][(int'(saved.wp) + HISTORY_DEPTH - dist_eff(saved.distance))
                            % HISTORY_DEPTH] + saved.thr;
    endfunction

    task automatic queue_item(input logic [15:0] raw);
        kept_t       k;
        logic        bad;
        logic [15:0] x;
        x = keep_in_history(raw);
        if (trigger_step(GEN, x, k, bad)) kept_planned++;
        tx_words.push_back(x);
    endtask

    // pulse train with random baseline, or plain noise
    function automatic logic [15:0] next_sample();
        if (wave_uniform) return 16'($urandom);
        if ($urandom_range(0, 24) == 0) begin
            wave_level = wave_level - int'($urandom_range(200, 12000));
        end else begin
            wave_level = wave_level + (wave_base - wave_level) / 4;
        end
        return 16'(wave_level + int'($urandom_range(0, 15)) - 8);
    endfunction

    function automatic int draw_wait(input logic calm);
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return int'($urandom_range(0, 13));
    endfunction

    // nothing queued, nothing in flight, nothing owed
    task automatic wait_idle();
        while (tx_words.size() != 0 || s_tvalid || kept_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        for (int i = 0; i < 2; i++) begin
            case (idx)
                REG_DISTANCE:  trig[i].distance = val[DIST_W-1:0];
                REG_THRESHOLD: trig[i].thr      = val[THR_W-1:0];
                REG_PRE:       trig[i].pre      = val[PRE_W-1:0];
                REG_POST:      trig[i].post     = val[POST_W-1:0];
                default: ;
            endcase
        end
    endtask

    task automatic set_config(input logic [DIST_W-1:0] d, input logic [THR_W-1:0] thr,
                              input logic [PRE_W-1:0] pre, input logic [POST_W-1:0] post);
        // an open window must not be moved back past the first stored sample
        while (trig[GEN].gate != 0 && dist_eff(d) + pre_eff(pre) > int'(trig[GEN].stored))
            queue_item(next_sample());
        wait_idle();
        write_reg(REG_DISTANCE, CFG_DAT_W'(d));
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_PRE, CFG_DAT_W'(pre));
        write_reg(REG_POST, CFG_DAT_W'(post));
    endtask

    // input side: words from the queue, random gap after each accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (tx_words.size() != 0) begin
                s_tdata  <= tx_words.pop_front();
                s_tvalid <= 1'b1;
                tx_gap   <= draw_wait(tx_calm);
                if ($urandom_range(0, 39) == 0) tx_calm <= !tx_calm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: random stall after each accepted word
    always @(posedge aclk) begin : sink
        int k;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (m_tvalid && m_tready) begin
            k = draw_wait(rx_calm);
            if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
            if (k != 0) begin
                m_tready <= 1'b0;
                rx_hold  <= k - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare kept words, then predict from accepted input words
    always @(posedge aclk) begin : scoreboard
        kept_t want;
        kept_t got;
        kept_t k;
        logic  bad;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser, m_tlast};
                if (kept_due.size() == 0) begin
                    $error("kept word %h with no window sample due", m_tdata);
                    fails++;
                end else begin
                    want = kept_due.pop_front();
                    if (got.sample !== want.sample) begin
                        $error("kept_sample: expected %h, got %h", want.sample, got.sample);
                        fails++;
                    end
                    if (got.first !== want.first) begin
                        $error("block_first: expected %b, got %b", want.first, got.first);
                        fails++;
                    end
                    if (got.last !== want.last) begin
                        $error("block_last: expected %b, got %b", want.last, got.last);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (trigger_step(CHK, s_tdata, k, bad)) kept_due.push_back(k);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        logic [15:0]       ramp [7];
        logic [DIST_W-1:0] d;
        logic [THR_W-1:0]  thr;
        logic [PRE_W-1:0]  pre;
        logic [POST_W-1:0] post;
        int                phase;
        int                n;
        int                random_items;
        int                i;
        for (int j = 0; j < 2; j++) begin
            trig[j]          = '0;
            trig[j].distance = DIST_RESET;
            trig[j].thr      = THR_RESET;
            trig[j].pre      = PRE_RESET;
            trig[j].post     = POST_RESET;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: too few samples for any gradient
        queue_item(16'h7FFF);
        queue_item(16'h8000);
        queue_item(16'hFFFF);
        queue_item(16'h0000);

        // distance zero saturates to one, one-sample window, wrapping gradients
        set_config(8'd0, 16'h0000, 11'd0, 14'd1);
        ramp = '{16'h0000, 16'h0100, 16'h0080, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        foreach (ramp[j]) queue_item(ramp[j]);

        // zero window: trigger disarms but emits nothing
        set_config(8'd1, 16'h0000, 11'd0, 14'd0);
        queue_item(16'h0000);
        queue_item(16'h8000);
        queue_item(16'h0000);

        // threshold extremes, gradient equal to the threshold
        set_config(8'd1, 16'h8000, 11'd0, 14'd1);
        queue_item(16'h0000);
        queue_item(16'h8000);
        set_config(8'd1, 16'h7FFF, 11'd0, 14'd1);
        queue_item(16'h7FFF);
        queue_item(16'h0000);

        // open a window, then shorten it and move the delay while it runs
        set_config(8'd1, 16'h0000, 11'd1, 14'd5);
        i = 0;
        while (trig[GEN].gate == 0 && i < 40) begin
            queue_item(i[0] ? 16'h0000 : 16'h1000);
            i++;
        end
        set_config(8'd1, 16'h0000, 11'd2, 14'd1);
        for (int j = 0; j < 6; j++) queue_item(j[0] ? 16'h0000 : 16'h1000);

        // random phases
        phase        = 0;
        random_items = 0;
        while ((random_items < 1050 || kept_planned < 48) && phase < 200) begin
            case ($urandom_range(0, 9))
                0:       d = 8'd0;
                1:       d = 8'd255;
                2:       d = 8'd128;
                3:       d = 8'd1;
                default: d = 8'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 19))
                0:       pre = 11'd2047;
                1:       pre = 11'd1024;
                default: pre = 11'($urandom_range(0, 12));
            endcase
            case ($urandom_range(0, 29))
                0:       post = 14'd16383;
                1, 2:    post = 14'd0;
                default: post = 14'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 7))
                0:       thr = 16'h8000;
                1:       thr = 16'h7FFF;
                2, 3:    thr = 16'($urandom);
                default: thr = 16'h0000 - 16'($urandom_range(20, 3000));
            endcase
            // register extremes early on
            if (phase == 3) begin
                d    = 8'd255;
                pre  = 11'd2047;
                post = 14'd16383;
            end else if (phase == 5) begin
                d    = 8'd128;
                pre  = 11'd1024;
                post = 14'd1;
            end
            set_config(d, thr, pre, post);
            wave_uniform = ($urandom_range(0, 3) == 0);
            wave_base    = int'($urandom_range(0, 40000)) - 20000;
            wave_level   = wave_base;
            n = $urandom_range(20, 100);
            repeat (n) queue_item(next_sample());
            random_items += n;
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
